// ----- src/stnh_pkg.sv -----
// Shared types and constants for the segment tile nearest hit block.
package stnh_pkg;

	localparam int CoordBitsDefault = 16;
	localparam int TileSizeBits = 8;
	localparam int KindBits = 2;
	localparam int DistBits = 34;
	localparam logic [DistBits-1:0] FarDistSq = 34'd10000000000;
	localparam int RegAddrBits = 4;

	localparam logic [1:0] KindSolid = 2'd0;
	localparam logic [1:0] KindOneWay = 2'd1;
	localparam logic [1:0] KindConveyor = 2'd2;
	localparam logic [1:0] KindOneWayAlt = 2'd3;

	localparam logic [1:0] RegStartX = 2'd0;
	localparam logic [1:0] RegStartY = 2'd1;
	localparam logic [1:0] RegEndX = 2'd2;
	localparam logic [1:0] RegEndY = 2'd3;

	// Edge under test.
	typedef enum logic [1:0] {
		EDGE_LEFT,
		EDGE_RIGHT,
		EDGE_BOTTOM,
		EDGE_TOP
	} edge_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_EDGE,
		ST_DIV,
		ST_OFFER,
		ST_OUT
	} ctrl_state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic      load_tile;
		logic      prep;
		logic      start_edge;
		edge_sel_t edge_sel;
		logic      div_step;
		logic      offer;
		logic      load_out;
		logic      clear;
	} stnh_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic use_tile;
		logic solid;
		logic dx_nz;
		logic dy_nz;
		logic div_done;
		logic last;
	} stnh_stat_t;

endpackage

// ----- src/stnh_ctrl.sv -----
// Controller state machine that sequences edge tests for each tile.
module stnh_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output stnh_pkg::stnh_cmd_t cmd,
	input  stnh_pkg::stnh_stat_t stat
);
	import stnh_pkg::*;

	ctrl_state_t state_q, state_d;
	edge_sel_t edge_q, edge_d;
	logic out_valid_q, out_valid_d;

	// Whether edge e is tested; solid tiles may test all four.
	function automatic logic next_edge_ok(input edge_sel_t e, input stnh_stat_t s);
		logic ok;
		begin
			case (e)
				EDGE_LEFT: ok = s.solid && s.dx_nz;
				EDGE_RIGHT: ok = s.solid && s.dx_nz;
				EDGE_BOTTOM: ok = s.solid && s.dy_nz;
				EDGE_TOP: ok = s.dy_nz;
				default: ok = 1'b0;
			endcase
			return ok;
		end
	endfunction

	always_comb begin
		state_d = state_q;
		edge_d = edge_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && !out_valid_q) state_d = ST_PREP;
			end
			ST_PREP: begin
				edge_d = EDGE_LEFT;
				state_d = ST_EDGE;
			end
			ST_EDGE: begin
				if (!stat.use_tile) begin
					state_d = stat.last ? ST_OUT : ST_IDLE;
				end else if (next_edge_ok(edge_q, stat)) begin
					state_d = ST_DIV;
				end else if (edge_q == EDGE_TOP) begin
					state_d = stat.last ? ST_OUT : ST_IDLE;
				end else begin
					edge_d = edge_sel_t'(edge_q + 2'd1);
				end
			end
			ST_DIV: begin
				if (stat.div_done) state_d = ST_OFFER;
			end
			ST_OFFER: begin
				if (edge_q == EDGE_TOP) begin
					state_d = stat.last ? ST_OUT : ST_IDLE;
				end else begin
					edge_d = edge_sel_t'(edge_q + 2'd1);
					state_d = ST_EDGE;
				end
			end
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.edge_sel = edge_q;
		in_ready = 1'b0;
		out_valid_d = out_valid_q && !out_ready;
		case (state_q)
			ST_IDLE: begin
				in_ready = !out_valid_q;
				cmd.load_tile = in_valid && !out_valid_q;
			end
			ST_PREP: cmd.prep = 1'b1;
			ST_EDGE: cmd.start_edge = stat.use_tile && next_edge_ok(edge_q, stat);
			ST_DIV: cmd.div_step = 1'b1;
			ST_OFFER: cmd.offer = 1'b1;
			ST_OUT: begin
				cmd.load_out = 1'b1;
				cmd.clear = 1'b1;
				out_valid_d = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			edge_q <= EDGE_LEFT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			edge_q <= edge_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE)
		else $error("input taken while busy");
	a_out_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |=> out_valid_q)
		else $error("result not presented");
	a_div_from_edge: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_DIV) |-> $past(state_q) == ST_EDGE)
		else $error("division entered wrongly");

endmodule

// ----- src/stnh_div.sv -----
// Restoring signed divider, one quotient bit per cycle while step is high, truncating toward zero.
module stnh_div #(
	parameter int NumBits = 56,
	parameter int DenBits = 26
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      step,
	input  logic signed [NumBits-1:0] num,
	input  logic signed [DenBits-1:0] den,
	output logic                      done,
	output logic signed [NumBits-1:0] quot
);
	localparam int CntBits = $clog2(NumBits + 1);

	logic [NumBits-1:0] q_q;
	logic [DenBits:0] rem_q;
	logic [DenBits-1:0] dmag_q;
	logic neg_q;
	logic [CntBits-1:0] cnt_q;
	logic [DenBits:0] trial;
	logic [DenBits:0] shifted;

	assign shifted = {rem_q[DenBits-1:0], q_q[NumBits-1]};
	assign trial = shifted - {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CntBits'(NumBits);
		end else if (step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num[NumBits-1] ? NumBits'(-num) : num;
			dmag_q <= den[DenBits-1] ? DenBits'(-den) : den;
			neg_q <= num[NumBits-1] ^ den[DenBits-1];
			rem_q <= '0;
		end else if (step && cnt_q != '0) begin
			if (!trial[DenBits]) begin
				rem_q <= trial;
				q_q <= {q_q[NumBits-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				q_q <= {q_q[NumBits-2:0], 1'b0};
			end
		end
	end

	assign done = (cnt_q == '0);
	assign quot = neg_q ? -$signed(q_q) : $signed(q_q);

endmodule

// ----- src/stnh_dp.sv -----
// Datapath: tile edges, box prefilter, crossing arithmetic and best-hit state.
module stnh_dp #(
	parameter int CoordBits = stnh_pkg::CoordBitsDefault
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  stnh_pkg::stnh_cmd_t               cmd,
	output stnh_pkg::stnh_stat_t              stat,
	input  logic signed [CoordBits-1:0]       sx,
	input  logic signed [CoordBits-1:0]       sy,
	input  logic signed [CoordBits-1:0]       ex,
	input  logic signed [CoordBits-1:0]       ey,
	input  logic signed [15:0]                tile_x,
	input  logic signed [15:0]                tile_y,
	input  logic [stnh_pkg::TileSizeBits-1:0] tile_w,
	input  logic [stnh_pkg::TileSizeBits-1:0] tile_h,
	input  logic [stnh_pkg::KindBits-1:0]     tile_kind,
	input  logic                              last_tile,
	output logic                              hit_found,
	output logic signed [CoordBits-1:0]       hit_x,
	output logic signed [CoordBits-1:0]       hit_y
);
	import stnh_pkg::*;

	localparam int CB = (CoordBits < 24) ? CoordBits : 24;
	localparam int EB = CB + 3;        // edges and deltas
	localparam int PB = 2 * EB + 2;    // products and numerators
	localparam int DB = DistBits + 2;

	logic signed [EB-1:0] sxe, sye, exe, eye;
	logic signed [EB-1:0] tx_q, ty_q, l_q, r_q, t_q, b_q, dx_q, dy_q;
	logic [TileSizeBits-1:0] w_q, h_q;
	logic half_q, solid_q, last_q, use_q;
	logic signed [PB-1:0] num;
	logic signed [EB-1:0] den;
	logic signed [PB-1:0] prod_a_q, prod_b_q;
	logic signed [EB-1:0] fix_q, dlo, dhi;
	logic div_done;
	logic signed [PB-1:0] quot;
	logic signed [EB-1:0] cx, cy, ddx, ddy;
	logic [DB-1:0] dist_sq;
	logic in_range;
	logic [DistBits-1:0] best_d_q;
	logic signed [CoordBits-1:0] best_x_q, best_y_q, hx_q, hy_q;
	logic any_q, hf_q;
	logic signed [EB-1:0] minx, maxx, miny, maxy;
	logic signed [EB-1:0] pa, pb, pc;

	assign sxe = EB'(signed'(sx[CB-1:0]));
	assign sye = EB'(signed'(sy[CB-1:0]));
	assign exe = EB'(signed'(ex[CB-1:0]));
	assign eye = EB'(signed'(ey[CB-1:0]));

	// Tile corners are taken as their raw 16 bits fitted to the coordinate width.
	always_ff @(posedge clk) begin
		if (cmd.load_tile) begin
			tx_q <= EB'(signed'(CB'($unsigned(tile_x))));
			ty_q <= EB'(signed'(CB'($unsigned(tile_y))));
			w_q <= tile_w;
			h_q <= tile_h;
			half_q <= tile_kind == KindOneWay || tile_kind == KindOneWayAlt;
			solid_q <= tile_kind == KindSolid;
			last_q <= last_tile;
		end
		if (cmd.prep) begin
			l_q <= tx_q;
			r_q <= tx_q + EB'(w_q);
			t_q <= half_q ? ty_q + EB'(h_q >> 1) : ty_q;
			b_q <= ty_q + EB'(h_q);
			dx_q <= exe - sxe;
			dy_q <= eye - sye;
		end
	end

	assign minx = (sxe < exe) ? sxe : exe;
	assign maxx = (sxe < exe) ? exe : sxe;
	assign miny = (sye < eye) ? sye : eye;
	assign maxy = (sye < eye) ? eye : sye;
	assign use_q = !(r_q < minx || l_q > maxx || b_q < miny || t_q > maxy ||
		(half_q && sye >= eye));

	// Operands: numerator = start*d_den + (edge - start)*d_other.
	always_comb begin
		case (cmd.edge_sel)
			EDGE_LEFT: begin pa = sye; pb = l_q - sxe; pc = dx_q; end
			EDGE_RIGHT: begin pa = sye; pb = r_q - sxe; pc = dx_q; end
			EDGE_BOTTOM: begin pa = sxe; pb = b_q - sye; pc = dy_q; end
			default: begin pa = sxe; pb = t_q - sye; pc = dy_q; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.start_edge) begin
			prod_a_q <= PB'(pa * pc);
			prod_b_q <= PB'(pb * ((cmd.edge_sel == EDGE_LEFT ||
				cmd.edge_sel == EDGE_RIGHT) ? dy_q : dx_q));
			fix_q <= (cmd.edge_sel == EDGE_LEFT) ? l_q :
				(cmd.edge_sel == EDGE_RIGHT) ? r_q :
				(cmd.edge_sel == EDGE_BOTTOM) ? b_q : t_q;
		end
	end

	// The divider start is a registered copy of start_edge, so the divider loads from registered products.
	logic start_div_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) start_div_q <= 1'b0;
		else start_div_q <= cmd.start_edge;
	end

	assign num = prod_a_q + prod_b_q;
	assign den = (cmd.edge_sel == EDGE_LEFT || cmd.edge_sel == EDGE_RIGHT) ? dx_q : dy_q;

	stnh_div #(.NumBits(PB), .DenBits(EB)) u_div (
		.clk(clk), .arst_n(arst_n), .start(start_div_q),
		.step(cmd.div_step && !start_div_q),
		.num(num), .den(den), .done(div_done), .quot(quot)
	);

	always_comb begin
		if (cmd.edge_sel == EDGE_LEFT || cmd.edge_sel == EDGE_RIGHT) begin
			cx = fix_q; cy = EB'(quot);
			dlo = t_q; dhi = b_q;
			in_range = ($signed(quot) <= PB'(b_q)) && ($signed(quot) >= PB'(t_q));
		end else begin
			cx = EB'(quot); cy = fix_q;
			dlo = l_q; dhi = r_q;
			in_range = ($signed(quot) <= PB'(r_q)) && ($signed(quot) >= PB'(l_q));
		end
		ddx = cx - sxe;
		ddy = cy - sye;
		dist_sq = DB'(ddx * ddx) + DB'(ddy * ddy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_d_q <= FarDistSq;
			best_x_q <= '0;
			best_y_q <= '0;
			any_q <= 1'b0;
		end else if (cmd.clear) begin
			best_d_q <= FarDistSq;
			best_x_q <= '0;
			best_y_q <= '0;
			any_q <= 1'b0;
		end else if (cmd.offer && in_range && dhi >= dlo) begin
			any_q <= 1'b1;
			if (DB'(best_d_q) > dist_sq) begin
				best_d_q <= DistBits'(dist_sq);
				best_x_q <= CoordBits'(cx[CB-1:0]);
				best_y_q <= CoordBits'(cy[CB-1:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			hf_q <= any_q;
			hx_q <= any_q ? best_x_q : CoordBits'(ex[CB-1:0]);
			hy_q <= any_q ? best_y_q : CoordBits'(ey[CB-1:0]);
		end
	end

	assign hit_found = hf_q;
	assign hit_x = hx_q;
	assign hit_y = hy_q;

	always_comb begin
		stat.use_tile = use_q;
		stat.solid = solid_q;
		stat.dx_nz = dx_q != '0;
		stat.dy_nz = dy_q != '0;
		stat.div_done = div_done && !start_div_q;
		stat.last = last_q;
	end

endmodule

// ----- src/segment_tile_nearest_hit_core.sv -----
// Top level of the segment tile nearest hit block.
// The block casts a segment set through the four APB registers against a stream of tiles,
// one transfer per tile, and after the tile marked last_tile emits one result transfer
// with the crossing nearest the start (or the end point when nothing was crossed).
// Coordinates are handled as COORD_BITS capped at 24 bits. A tile that the box prefilter
// drops leaves from the edge state with no edge tested; a solid tile may have every edge tested.
// Each tested edge goes through a setup step, the one shared bit-serial divider and a
// compare step; an edge that is not tested is skipped. The last tile of a query adds a
// step to load the result. A new tile is taken only once the previous one is finished and
// any pending result transfer has gone out.
module segment_tile_nearest_hit_core #(
	parameter int COORD_BITS = stnh_pkg::CoordBitsDefault
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [stnh_pkg::RegAddrBits-1:0]  paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [15:0]                tile_x,
	input  logic signed [15:0]                tile_y,
	input  logic [stnh_pkg::TileSizeBits-1:0] tile_w,
	input  logic [stnh_pkg::TileSizeBits-1:0] tile_h,
	input  logic [stnh_pkg::KindBits-1:0]     tile_kind,
	input  logic                              last_tile,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit_found,
	output logic signed [COORD_BITS-1:0]      hit_x,
	output logic signed [COORD_BITS-1:0]      hit_y
);
	import stnh_pkg::*;

	logic signed [COORD_BITS-1:0] sx_q, sy_q, ex_q, ey_q;
	stnh_cmd_t cmd;
	stnh_stat_t stat;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	// Registers sit at byte addresses 0, 4, 8 and 12; other addresses are ignored on writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= '0;
			sy_q <= '0;
			ex_q <= '0;
			ey_q <= '0;
		end else if (wr && paddr[1:0] == 2'b00) begin
			case (paddr[3:2])
				RegStartX: sx_q <= COORD_BITS'(pwdata);
				RegStartY: sy_q <= COORD_BITS'(pwdata);
				RegEndX: ex_q <= COORD_BITS'(pwdata);
				RegEndY: ey_q <= COORD_BITS'(pwdata);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			RegStartX: prdata = 32'(sx_q);
			RegStartY: prdata = 32'(sy_q);
			RegEndX: prdata = 32'(ex_q);
			default: prdata = 32'(ey_q);
		endcase
	end

	stnh_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat)
	);

	stnh_dp #(.CoordBits(COORD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.sx(sx_q), .sy(sy_q), .ex(ex_q), .ey(ey_q),
		.tile_x(tile_x), .tile_y(tile_y), .tile_w(tile_w), .tile_h(tile_h),
		.tile_kind(tile_kind), .last_tile(last_tile),
		.hit_found(hit_found), .hit_x(hit_x), .hit_y(hit_y)
	);

endmodule
